>>> design/cst_pkg.sv
// Package for the counting semaphore table: sizes, status and mode codes,
// and the per-slot record kept in slot memory. No dependencies.
package cst_pkg;
	localparam int NUM_SEMS    = 16;
	localparam int SLOT_W      = 4;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = 3;
	localparam int FILL_W      = 4;
	localparam int PID_BITS    = 8;
	localparam int WADDR_W     = SLOT_W + QPTR_W;
	localparam int WDEPTH      = NUM_SEMS * QUEUE_DEPTH;
	localparam int KEY_W       = 64;
	localparam int COUNT_W     = 16;
	localparam int REFS_W      = 8;

	localparam logic [1:0] MODE_OPEN  = 2'd0;
	localparam logic [1:0] MODE_CLOSE = 2'd1;
	localparam logic [1:0] MODE_WAIT  = 2'd2;
	localparam logic [1:0] MODE_POST  = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [2:0] ST_SATURATED  = 3'd4;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [REFS_W-1:0]  refs;
		logic [QPTR_W-1:0]  head;
		logic [FILL_W-1:0]  fill;
	} rec_t;

	localparam int REC_W = $bits(rec_t);
endpackage

>>> design/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

>>> design/counting_semaphore_table_top.sv
// Counting semaphore table: 16 named semaphores, each with an 8-deep FIFO of
// waiting pids. Depends on cst_pkg and cst_ram.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one operation word:
//   mode, name_key, init_value, sem_index, caller_pid. The output channel
//   (out_valid / out_stall) returns exactly one result word per operation:
//   status, slot_out, must_block, wake_valid, wake_pid.
//   An operation goes through a key lookup step, a slot memory read step
//   and, for a post that releases a waiter, a further step to read the
//   waiter memory (states S_LOOK, S_READ, S_WAKE). A new word is taken
//   the cycle after the result is registered, so a new word is not taken
//   before the last one is through; the slot record memory
//   read-modify-write sets this.
//   The result register holds its word while out_stall is high; the next
//   operation is taken in meanwhile and waits at its final step until the
//   result register is free.
//   Reset (arst_n low) frees every slot and empties the output register.
//   Keys, counts and waiter pids are written when a slot is claimed or a
//   waiter is queued, so the memories need no clearing pass.
module counting_semaphore_table_top
	import cst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [KEY_W-1:0]    name_key,
	input  logic [COUNT_W-1:0]  init_value,
	input  logic [SLOT_W-1:0]   sem_index,
	input  logic [PID_BITS-1:0] caller_pid,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [SLOT_W-1:0]   slot_out,
	output logic                must_block,
	output logic                wake_valid,
	output logic [PID_BITS-1:0] wake_pid
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_READ = 4'b0100,
		S_WAKE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [1:0]          mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [COUNT_W-1:0]  init_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [PID_BITS-1:0] pid_q;

	logic [NUM_SEMS-1:0] use_q;
	logic [KEY_W-1:0]    slot_key_q [NUM_SEMS];

	logic [SLOT_W-1:0]   s_q;
	logic                found_q, claim_q;

	logic                out_valid_q;
	logic [2:0]          status_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic                must_block_q, wake_valid_q;
	logic [PID_BITS-1:0] wake_pid_q;

	// lookup results
	logic                match_hit, free_hit;
	logic [SLOT_W-1:0]   match_idx, free_idx;
	logic [SLOT_W-1:0]   look_s;
	logic                look_found, look_claim;

	// memory ports
	logic                rec_we;
	logic [SLOT_W-1:0]   rec_raddr;
	rec_t                rec_rd, rec_wd;
	logic [REC_W-1:0]    rec_rd_raw;
	logic                wt_we;
	logic [WADDR_W-1:0]  wt_waddr, wt_raddr;
	logic [PID_BITS-1:0] wt_rd;

	logic                out_free, emit;
	logic [2:0]          status_d;
	logic                must_block_d, wake_valid_d;
	logic [PID_BITS-1:0] wake_pid_d;
	logic                use_set, use_clr, key_we;
	logic [REFS_W-1:0]   refs_dec;
	logic [QPTR_W-1:0]   tail_pos;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_out   = slot_out_q;
	assign must_block = must_block_q;
	assign wake_valid = wake_valid_q;
	assign wake_pid   = wake_pid_q;
	assign out_free   = !out_valid_q || !out_stall;

	// compare the key against every in-use slot and find the lowest free slot
	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		free_hit  = 1'b0;
		free_idx  = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (use_q[i] && slot_key_q[i] == key_q) begin
				match_hit = 1'b1;
				match_idx = SLOT_W'(i);
			end
			if (!use_q[i]) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// pick the slot this word works on
	always_comb begin
		look_s     = idx_q;
		look_found = use_q[idx_q];
		look_claim = 1'b0;
		unique case (mode_q)
			MODE_OPEN: begin
				look_claim = !match_hit && free_hit;
				look_found = match_hit || free_hit;
				look_s     = match_hit ? match_idx : free_idx;
			end
			MODE_CLOSE: begin
				look_found = match_hit;
				look_s     = match_idx;
			end
			default: begin
			end
		endcase
	end

	assign rec_raddr = (state_q == S_LOOK) ? look_s : s_q;
	assign rec_rd    = rec_t'(rec_rd_raw);
	assign wt_raddr  = {s_q, rec_rd.head};
	assign tail_pos  = rec_rd.head + rec_rd.fill[QPTR_W-1:0];
	assign wt_waddr  = {s_q, tail_pos};
	assign refs_dec  = (rec_rd.refs != '0) ? rec_rd.refs - 1'b1 : rec_rd.refs;

	// modify the slot record and decide the result word
	always_comb begin
		state_d      = state_q;
		rec_we       = 1'b0;
		rec_wd       = rec_rd;
		wt_we        = 1'b0;
		emit         = 1'b0;
		status_d     = ST_OK;
		must_block_d = 1'b0;
		wake_valid_d = 1'b0;
		wake_pid_d   = '0;
		use_set      = 1'b0;
		use_clr      = 1'b0;
		key_we       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LOOK;
			end
			S_LOOK: state_d = S_READ;
			S_READ: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (!found_q) begin
						status_d = (mode_q == MODE_OPEN) ? ST_FULL : ST_NOT_FOUND;
					end else begin
						unique case (mode_q)
							MODE_OPEN: begin
								rec_we = 1'b1;
								if (claim_q) begin
									rec_wd.count = init_q;
									rec_wd.refs  = REFS_W'(1);
									rec_wd.head  = '0;
									rec_wd.fill  = '0;
									use_set      = 1'b1;
									key_we       = 1'b1;
								end else if (rec_rd.refs != '1) begin
									rec_wd.refs = rec_rd.refs + 1'b1;
								end
							end
							MODE_CLOSE: begin
								rec_we      = 1'b1;
								rec_wd.refs = refs_dec;
								use_clr     = (refs_dec == '0);
							end
							MODE_WAIT: begin
								if (rec_rd.count != '0) begin
									rec_we       = 1'b1;
									rec_wd.count = rec_rd.count - 1'b1;
								end else if (rec_rd.fill < FILL_W'(QUEUE_DEPTH)) begin
									rec_we       = 1'b1;
									wt_we        = 1'b1;
									rec_wd.fill  = rec_rd.fill + 1'b1;
									must_block_d = 1'b1;
								end else begin
									status_d = ST_QUEUE_FULL;
								end
							end
							MODE_POST: begin
								if (rec_rd.fill != '0) begin
									emit    = 1'b0;
									state_d = S_WAKE;
								end else if (rec_rd.count == '1) begin
									status_d = ST_SATURATED;
								end else begin
									rec_we       = 1'b1;
									rec_wd.count = rec_rd.count + 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_WAKE: begin
				if (out_free) begin
					emit         = 1'b1;
					state_d      = S_IDLE;
					rec_we       = 1'b1;
					rec_wd.head  = rec_rd.head + 1'b1;
					rec_wd.fill  = rec_rd.fill - 1'b1;
					wake_valid_d = 1'b1;
					wake_pid_d   = wt_rd;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			use_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (use_set) use_q[s_q] <= 1'b1;
			if (use_clr) use_q[s_q] <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// capture the input word, the lookup and the result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			key_q  <= name_key;
			init_q <= init_value;
			idx_q  <= sem_index;
			pid_q  <= caller_pid;
		end
		if (state_q == S_LOOK) begin
			s_q     <= look_s;
			found_q <= look_found;
			claim_q <= look_claim;
		end
		if (key_we) slot_key_q[s_q] <= key_q;
		if (emit) begin
			status_q     <= status_d;
			slot_out_q   <= (mode_q == MODE_OPEN && found_q) ? s_q : '0;
			must_block_q <= must_block_d;
			wake_valid_q <= wake_valid_d;
			wake_pid_q   <= wake_pid_d;
		end
	end

	cst_ram #(.WIDTH(REC_W), .DEPTH(NUM_SEMS)) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(s_q),
		.wdata(rec_wd),
		.raddr(rec_raddr),
		.rdata(rec_rd_raw)
	);

	cst_ram #(.WIDTH(PID_BITS), .DEPTH(WDEPTH)) u_wait_ram (
		.clk  (clk),
		.we   (wt_we),
		.waddr(wt_waddr),
		.wdata(pid_q),
		.raddr(wt_raddr),
		.rdata(wt_rd)
	);

	// a word never both blocks a caller and wakes one
	a_block_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(must_block_q && wake_valid_q))
		else $error("must_block and wake_valid both set");

	// a wake always reports ok
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wake_valid_q) |-> (status_q == ST_OK))
		else $error("wake with error status");

	// at most one slot is freed per cycle
	a_use_step: assert property (@(posedge clk) disable iff (!arst_n)
		$countones($past(use_q)) <= $countones(use_q) + 1)
		else $error("more than one slot freed at once");

	// the record memory is written only while finishing a word
	a_rec_write: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> emit)
		else $error("record written outside the final step");
endmodule

>>> tb/tb_counting_semaphore_table_top.sv
// Testbench for counting_semaphore_table_top: drives open, close, wait and post
// words, predicts each result word and checks it in order. Depends on cst_pkg.
`timescale 1ns / 1ps

class sem_scoreboard;
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot_out;
		logic       must_block;
		logic       wake_valid;
		logic [7:0] wake_pid;
	} result_t;

	bit         used [16];
	bit  [63:0] keys [16];
	int         counts [16];
	int         refs [16];
	bit  [7:0]  waiters [16][8];
	int         head [16];
	int         fill [16];
	result_t    pending [$];
	int         mismatches;

	function new();
		int i;
		for (i = 0; i < 16; i++) begin
			used[i] = 0;
			head[i] = 0;
			fill[i] = 0;
		end
		mismatches = 0;
	endfunction

	// Predict the result of one accepted word and queue it.
	function void note_word(logic [1:0] op, logic [63:0] key, logic [15:0] init,
			logic [3:0] idx, logic [7:0] pid);
		result_t r;
		int s;
		r = '0;
		s = 16;
		if (op == cst_pkg::MODE_OPEN || op == cst_pkg::MODE_CLOSE) begin
			for (int i = 0; i < 16; i++)
				if (s == 16 && used[i] && keys[i] == key) s = i;
		end
		if (op == cst_pkg::MODE_OPEN) begin
			if (s == 16) begin
				for (int i = 0; i < 16; i++)
					if (s == 16 && !used[i]) s = i;
				if (s < 16) begin
					used[s] = 1; keys[s] = key; counts[s] = init;
					refs[s] = 0; head[s] = 0; fill[s] = 0;
				end
			end
			if (s < 16) begin
				if (refs[s] < 255) refs[s]++;
				r.slot_out = 4'(s);
			end else r.status = cst_pkg::ST_FULL;
		end else if (op == cst_pkg::MODE_CLOSE) begin
			if (s == 16) r.status = cst_pkg::ST_NOT_FOUND;
			else begin
				if (refs[s] > 0) refs[s]--;
				if (refs[s] == 0) used[s] = 0;
			end
		end else if (!used[idx]) begin
			r.status = cst_pkg::ST_NOT_FOUND;
		end else if (op == cst_pkg::MODE_WAIT) begin
			if (counts[idx] > 0) counts[idx]--;
			else if (fill[idx] < 8) begin
				waiters[idx][(head[idx] + fill[idx]) % 8] = pid;
				fill[idx]++;
				r.must_block = 1;
			end else r.status = cst_pkg::ST_QUEUE_FULL;
		end else begin
			if (fill[idx] > 0) begin
				r.wake_pid = waiters[idx][head[idx]];
				r.wake_valid = 1;
				head[idx] = (head[idx] + 1) % 8;
				fill[idx]--;
			end else if (counts[idx] >= 65535) r.status = cst_pkg::ST_SATURATED;
			else counts[idx]++;
		end
		pending.push_back(r);
	endfunction

	// Compare one result word with the oldest prediction.
	function void check_word(result_t got);
		result_t exp_r;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result word %h", got);
			return;
		end
		exp_r = pending.pop_front();
		if (got !== exp_r) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected st=%0d slot=%0d blk=%0d wv=%0d pid=%0d",
					exp_r.status, exp_r.slot_out, exp_r.must_block, exp_r.wake_valid,
					exp_r.wake_pid);
				$display("          got      st=%0d slot=%0d blk=%0d wv=%0d pid=%0d",
					got.status, got.slot_out, got.must_block, got.wake_valid,
					got.wake_pid);
			end
		end
	endfunction
endclass

module tb_counting_semaphore_table_top;
	import cst_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  mode = MODE_OPEN;
	logic [63:0] name_key = '0;
	logic [15:0] init_value = '0;
	logic [3:0]  sem_index = '0;
	logic [7:0]  caller_pid = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic        must_block;
	logic        wake_valid;
	logic [7:0]  wake_pid;

	sem_scoreboard sb = new();
	bit          sending_done = 0;
	logic [63:0] key_pool [6];

	counting_semaphore_table_top u_top (.*);

	always #2 clk = ~clk;

	// Pick a gap: mostly none or short, sometimes long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one word and hold it until accepted.
	task automatic send_word(logic [1:0] op, logic [63:0] key, logic [15:0] init,
			logic [3:0] idx, logic [7:0] pid);
		in_valid   <= 1;
		mode       <= op;
		name_key   <= key;
		init_value <= init;
		sem_index  <= idx;
		caller_pid <= pid;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(op, key, init, idx, pid);
	endtask

	task automatic idle_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Stimulus: directed corners, then random sequences over a small key pool.
	initial begin
		logic [1:0] op;
		int p;
		key_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
			64'hA5A5_5A5A_0F0F_F0F0, 64'h5A5A_A5A5_F0F0_0F0F};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_word(MODE_WAIT, 64'h0, 16'h0, 4'd0, 8'h00);
		send_word(MODE_POST, 64'h0, 16'h0, 4'd15, 8'hFF);
		send_word(MODE_CLOSE, 64'h1234, 16'h0, 4'd0, 8'h0);
		send_word(MODE_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd0, 8'h0);
		send_word(MODE_POST, 64'h0, 16'h0, 4'd0, 8'h0);
		send_word(MODE_OPEN, 64'h0, 16'h0, 4'd0, 8'h0);
		send_word(MODE_WAIT, 64'h0, 16'h0, 4'd1, 8'hFF);
		send_word(MODE_WAIT, 64'h0, 16'h0, 4'd1, 8'h00);
		send_word(MODE_POST, 64'h0, 16'h0, 4'd1, 8'h0);
		send_word(MODE_CLOSE, 64'h0, 16'h0, 4'd0, 8'h0);
		send_word(MODE_WAIT, 64'h0, 16'h0, 4'd1, 8'h0);
		for (int i = 2; i < 17; i++)
			send_word(MODE_OPEN, 64'h100 + i, 16'd0, 4'd0, 8'h0);
		// Fill one queue past its depth.
		for (int i = 0; i < 9; i++)
			send_word(MODE_WAIT, 64'h0, 16'h0, 4'd2, 8'(i * 29));
		in_valid <= 0;
		// Random part.
		for (int n = 0; n < 400; n++) begin
			idle_gap();
			p = $urandom_range(0, 99);
			op = 2'($urandom_range(0, 3));
			if (p < 85)
				send_word(op, key_pool[$urandom_range(0, 5)] ^ (p < 10 ? 64'h100 : 64'h0),
					16'($urandom_range(0, 3) == 0 ? 16'hFFFE + $urandom_range(0, 1)
						: $urandom_range(0, 3)),
					4'($urandom_range(0, 15)), 8'($urandom));
			else
				send_word(op, {$urandom, $urandom}, 16'($urandom),
					4'($urandom), 8'($urandom));
		end
		// Close with one more open at a high initial count.
		send_word(MODE_OPEN, 64'h77, 16'hFFFD, 4'd0, 8'h0);
		in_valid <= 0;
		sending_done = 1;
	end

	// Receiver stalls, with one long hold-off while the sender keeps going.
	initial begin
		int g;
		@(posedge arst_n);
		repeat (60) @(posedge clk);
		out_stall <= 1;
		repeat (80) @(posedge clk);
		forever begin
			g = gap_len();
			out_stall <= (g > 0);
			repeat (g > 0 ? g : 1) @(posedge clk);
			if (g > 0) begin
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	// Check each accepted result word.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word({status, slot_out, must_block, wake_valid, wake_pid});
	end

	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
